### src/iorht_pkg.sv
// iorht_pkg: shared types and constants of the i/o region handle table
// no dependencies
`timescale 1ns / 1ps

package iorht_pkg;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_MAP   = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;
   localparam logic [1:0] OP_INFO  = 2'd3;

   localparam logic [1:0] WIDTH_NONE = 2'd3;

   localparam logic [63:0] ADDR_LIMIT = 64'h7fff_ffff_ffff_ffff;

   typedef struct packed {
      logic [62:0] base;
      logic [62:0] length;
   } iorht_entry_type;

   typedef struct packed {
      logic clear_all;
      logic rd_en;
      logic wr_en;
   } iorht_cmd_type;

endpackage

### src/iorht_store.sv
// iorht_store: entry memory (base and length, registered read) plus valid bits
// depends on iorht_pkg
`timescale 1ns / 1ps

module iorht_store #(
   parameter int TABLE_ENTRIES = 16,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  iorht_pkg::iorht_cmd_type  cmd,
   input  logic [IDX_W-1:0]          rd_idx,
   input  logic [IDX_W-1:0]          wr_idx,
   input  iorht_pkg::iorht_entry_type wr_data,
   output iorht_pkg::iorht_entry_type rd_data,
   output logic [TABLE_ENTRIES-1:0]  valid
);
   import iorht_pkg::*;

   iorht_entry_type mem [TABLE_ENTRIES];
   iorht_entry_type rd_data_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

### src/iorht_ctrl.sv
// iorht_ctrl: transaction sequencer, map scan, handle lookup and access check
// depends on iorht_pkg; drives iorht_store
`timescale 1ns / 1ps

module iorht_ctrl #(
   parameter int TABLE_ENTRIES = 16,
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic signed [63:0]         req_base_address,
   input  logic signed [63:0]         req_region_length,
   input  logic [7:0]                 req_handle,
   input  logic signed [63:0]         req_byte_offset,
   input  logic [1:0]                 req_access_width,
   output logic                       rsp_strobe,
   output logic                       rsp_ok,
   output logic [6:0]                 rsp_result_handle,
   output logic [62:0]                rsp_entry_base_out,
   output logic [62:0]                rsp_entry_length_out,
   output logic [62:0]                rsp_target_address,
   output iorht_pkg::iorht_cmd_type   cmd,
   output logic [IDX_W-1:0]           rd_idx,
   output logic [IDX_W-1:0]           wr_idx,
   output iorht_pkg::iorht_entry_type wr_data,
   input  iorht_pkg::iorht_entry_type rd_data,
   input  logic [TABLE_ENTRIES-1:0]   valid
);
   import iorht_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  op_ff, op_in;
   logic [63:0] base_ff, base_in;
   logic [63:0] len_ff, len_in;
   logic [7:0]  handle_ff, handle_in;
   logic [63:0] off_ff, off_in;
   logic [1:0]  wcode_ff, wcode_in;

   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             free_vld_ff, free_vld_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic        ok_ff, ok_in;
   logic [6:0]  rh_ff, rh_in;
   logic [62:0] ib_ff, ib_in;
   logic [62:0] il_ff, il_in;
   logic [62:0] ta_ff, ta_in;

   logic [7:0]       handle_m1;
   logic [IDX_W-1:0] slot;
   logic             handle_ok;
   logic [63:0]      map_end;
   logic             map_ok;
   logic [2:0]       wbytes;
   logic [63:0]      acc_end;
   logic             acc_ok;
   logic             hit;
   logic             free_any;
   logic [IDX_W-1:0] free_now;

   assign handle_m1 = handle_ff - 8'd1;
   assign slot      = handle_m1[IDX_W-1:0];
   assign handle_ok = (handle_ff != 8'd0) && (handle_ff <= 8'(TABLE_ENTRIES)) && valid[slot];

   assign map_end = 64'(base_ff[62:0]) + 64'(len_ff[62:0]);
   assign map_ok  = (base_ff != 64'd0) && !base_ff[63] && (len_ff != 64'd0) && !len_ff[63]
                    && (map_end <= ADDR_LIMIT);

   assign wbytes  = 3'b001 << wcode_ff;
   assign acc_end = 64'(off_ff[62:0]) + 64'(wbytes);
   assign acc_ok  = (wcode_ff != WIDTH_NONE) && !off_ff[63]
                    && ((off_ff[2:0] & (wbytes - 3'd1)) == 3'd0)
                    && (acc_end <= 64'(rd_data.length));

   assign hit      = valid[cmp_idx_ff] && (rd_data.base == base_ff[62:0])
                     && (rd_data.length == len_ff[62:0]);
   assign free_any = free_vld_ff || !valid[cmp_idx_ff];
   assign free_now = free_vld_ff ? free_idx_ff : cmp_idx_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      base_in     = base_ff;
      len_in      = len_ff;
      handle_in   = handle_ff;
      off_in      = off_ff;
      wcode_in    = wcode_ff;
      cnt_in      = cnt_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      ok_in       = ok_ff;
      rh_in       = rh_ff;
      ib_in       = ib_ff;
      il_in       = il_ff;
      ta_in       = ta_ff;
      cmd         = '0;
      rd_idx      = '0;
      wr_idx      = free_now;
      wr_data     = '{base: base_ff[62:0], length: len_ff[62:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               base_in   = req_base_address;
               len_in    = req_region_length;
               handle_in = req_handle;
               off_in    = req_byte_offset;
               wcode_in  = req_access_width;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ok_in = 1'b0;
            rh_in = '0;
            ib_in = '0;
            il_in = '0;
            ta_in = '0;
            unique case (op_ff) inside
               OP_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  ok_in         = 1'b1;
                  state_in      = ST_RESP;
               end
               OP_MAP: begin
                  cnt_in      = '0;
                  cmp_vld_in  = 1'b0;
                  free_vld_in = 1'b0;
                  state_in    = map_ok ? ST_SCAN : ST_RESP;
               end
               OP_CHECK, OP_INFO: begin
                  if (handle_ok) begin
                     cmd.rd_en = 1'b1;
                     rd_idx    = slot;
                     state_in  = ST_LOOKUP;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the entry read the cycle before
            if (cnt_ff < (IDX_W + 1)'(TABLE_ENTRIES)) begin
               cmd.rd_en = 1'b1;
               rd_idx    = cnt_ff[IDX_W-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            cmp_vld_in = cmd.rd_en;
            cmp_idx_in = rd_idx;
            if (cmp_vld_ff) begin
               if (!free_vld_ff && !valid[cmp_idx_ff]) begin
                  free_vld_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (hit) begin
                  ok_in    = 1'b1;
                  rh_in    = 7'(cmp_idx_ff) + 7'd1;
                  state_in = ST_RESP;
               end else if (cmp_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  if (free_any) begin
                     cmd.wr_en = 1'b1;
                     ok_in     = 1'b1;
                     rh_in     = 7'(free_now) + 7'd1;
                  end
                  state_in = ST_RESP;
               end
            end
         end
         ST_LOOKUP: begin
            if (op_ff == OP_CHECK) begin
               if (acc_ok) begin
                  ok_in = 1'b1;
                  ta_in = rd_data.base + off_ff[62:0];
               end
            end else begin
               ok_in = 1'b1;
               ib_in = rd_data.base;
               il_in = rd_data.length;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cmp_vld_ff  <= 1'b0;
         free_vld_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         free_vld_ff <= free_vld_in;
         cnt_ff      <= cnt_in;
         op_ff       <= op_in;
         base_ff     <= base_in;
         len_ff      <= len_in;
         handle_ff   <= handle_in;
         off_ff      <= off_in;
         wcode_ff    <= wcode_in;
         cmp_idx_ff  <= cmp_idx_in;
         free_idx_ff <= free_idx_in;
         ok_ff       <= ok_in;
         rh_ff       <= rh_in;
         ib_ff       <= ib_in;
         il_ff       <= il_in;
         ta_ff       <= ta_in;
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = (state_ff == ST_RESP);
   assign rsp_ok               = ok_ff;
   assign rsp_result_handle    = rh_ff;
   assign rsp_entry_base_out   = ib_ff;
   assign rsp_entry_length_out = il_ff;
   assign rsp_target_address   = ta_ff;

endmodule

### src/io_region_handle_table_core.sv
// Handle table of i/o regions. One transaction is taken when start is high and busy is
// low, and exactly one result follows on rsp_strobe for a single cycle; the receiver
// cannot stall it. Clear, a rejected map and a lookup on a bad handle go straight to the
// result; get info and check access on a valid handle first read the entry, and an
// accepted map runs the map scan, which reads the entry memory one entry per cycle
// through its single read port and stops early on an identical entry. busy stays high
// until the result cycle ends, so a new transaction can start the cycle after the strobe.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// top level: depends on iorht_pkg, iorht_ctrl, iorht_store
`timescale 1ns / 1ps

module io_region_handle_table_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [63:0] req_base_address,
   input  logic signed [63:0] req_region_length,
   input  logic [7:0]         req_handle,
   input  logic signed [63:0] req_byte_offset,
   input  logic [1:0]         req_access_width,
   output logic               rsp_strobe,
   output logic               rsp_ok,
   output logic [6:0]         rsp_result_handle,
   output logic [62:0]        rsp_entry_base_out,
   output logic [62:0]        rsp_entry_length_out,
   output logic [62:0]        rsp_target_address
);
   import iorht_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   iorht_cmd_type            cmd;
   logic [IDX_W-1:0]         rd_idx;
   logic [IDX_W-1:0]         wr_idx;
   iorht_entry_type          wr_data;
   iorht_entry_type          rd_data;
   logic [TABLE_ENTRIES-1:0] valid;

   iorht_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_base_address     (req_base_address),
      .req_region_length    (req_region_length),
      .req_handle           (req_handle),
      .req_byte_offset      (req_byte_offset),
      .req_access_width     (req_access_width),
      .rsp_strobe           (rsp_strobe),
      .rsp_ok               (rsp_ok),
      .rsp_result_handle    (rsp_result_handle),
      .rsp_entry_base_out   (rsp_entry_base_out),
      .rsp_entry_length_out (rsp_entry_length_out),
      .rsp_target_address   (rsp_target_address),
      .cmd                  (cmd),
      .rd_idx               (rd_idx),
      .wr_idx               (wr_idx),
      .wr_data              (wr_data),
      .rd_data              (rd_data),
      .valid                (valid)
   );

   iorht_store #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_data (rd_data),
      .valid   (valid)
   );

endmodule

### src/iorht_checker.sv
// iorht_checker: port-level checks of the handle table top level, with its bind
// depends on io_region_handle_table_core
`timescale 1ns / 1ps

module iorht_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_ok,
   input logic [6:0]  rsp_result_handle,
   input logic [62:0] rsp_entry_base_out,
   input logic [62:0] rsp_entry_length_out,
   input logic [62:0] rsp_target_address
);

   // a result only comes out of an accepted transaction
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe without a transaction in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after acceptance");

   // one result per transaction
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_result_handle == 7'd0 && rsp_target_address == 63'd0
         && rsp_entry_base_out == 63'd0 && rsp_entry_length_out == 63'd0))
      else $error("rejected transaction carries nonzero fields");

   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_handle != 7'd0) |-> rsp_ok)
      else $error("handle returned without ok");

endmodule

bind io_region_handle_table_core iorht_checker u_iorht_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_strobe           (rsp_strobe),
   .rsp_ok               (rsp_ok),
   .rsp_result_handle    (rsp_result_handle),
   .rsp_entry_base_out   (rsp_entry_base_out),
   .rsp_entry_length_out (rsp_entry_length_out),
   .rsp_target_address   (rsp_target_address)
);

### tb/sv/testbench.sv
// testbench for io_region_handle_table_core: directed and random transactions checked
// against a tracker of the region table that predicts every result in order
// depends on iorht_pkg and io_region_handle_table_core
`timescale 1ns / 1ps

import iorht_pkg::*;

localparam int TABLE_SIZE = 16;

typedef struct {
   logic        ok;
   logic [6:0]  handle;
   logic [62:0] base;
   logic [62:0] length;
   logic [62:0] target;
} region_result_type;

class region_table_tracker;
   logic              valid_q[TABLE_SIZE];
   logic [62:0]       base_q[TABLE_SIZE];
   logic [62:0]       len_q[TABLE_SIZE];
   region_result_type pending_results[$];
   int                error_count;
   int                op_count[4];
   int                map_granted;
   int                full_rejects;
   int                result_count;

   function new();
      clear_regions();
   endfunction

   function void clear_regions();
      for (int k = 0; k < TABLE_SIZE; k++) begin
         valid_q[k] = 1'b0;
         base_q[k] = '0;
         len_q[k] = '0;
      end
   endfunction

   task report(string msg);
      error_count++;
      if (error_count <= 50)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function int slot_for(logic [7:0] h);
      if (h == 0 || h > TABLE_SIZE)
         return -1;
      if (!valid_q[h - 1])
         return -1;
      return int'(h) - 1;
   endfunction

   // predict the result of one accepted transaction and update the region state
   function void apply_request(logic [1:0] op, logic [63:0] b, logic [63:0] l,
                               logic [7:0] h, logic [63:0] off, logic [1:0] w);
      region_result_type res;
      int                slot;
      logic              fits;
      logic [63:0]       width_bytes;
      logic [63:0]       rl;
      res = '{ok: 1'b0, handle: '0, base: '0, length: '0, target: '0};
      op_count[op]++;
      case (op)
         OP_CLEAR: begin
            clear_regions();
            res.ok = 1'b1;
         end
         OP_MAP: begin
            fits = b != 0 && !b[63] && l != 0 && !l[63] && l <= ADDR_LIMIT - b;
            if (fits) begin
               for (int k = 0; k < TABLE_SIZE && res.handle == 0; k++)
                  if (valid_q[k] && base_q[k] == b[62:0] && len_q[k] == l[62:0])
                     res.handle = 7'(k + 1);
               for (int k = 0; k < TABLE_SIZE && res.handle == 0; k++)
                  if (!valid_q[k]) begin
                     valid_q[k] = 1'b1;
                     base_q[k] = b[62:0];
                     len_q[k] = l[62:0];
                     res.handle = 7'(k + 1);
                  end
               res.ok = res.handle != 0;
               if (res.ok)
                  map_granted++;
               else
                  full_rejects++;
            end
         end
         OP_CHECK: begin
            slot = slot_for(h);
            if (slot >= 0 && w != WIDTH_NONE && !off[63]) begin
               width_bytes = 64'd1 << w;
               rl = {1'b0, len_q[slot]};
               if ((off & (width_bytes - 1)) == 0 && off <= rl && rl - off >= width_bytes) begin
                  res.ok = 1'b1;
                  res.target = base_q[slot] + off[62:0];
               end
            end
         end
         default: begin
            slot = slot_for(h);
            if (slot >= 0) begin
               res.ok = 1'b1;
               res.base = base_q[slot];
               res.length = len_q[slot];
            end
         end
      endcase
      pending_results.push_back(res);
   endfunction

   task compare_result(region_result_type got);
      region_result_type want;
      result_count++;
      if (pending_results.size() == 0) begin
         report("result strobe with no transaction pending");
         return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok)
         report($sformatf("ok %0b, predicted %0b", got.ok, want.ok));
      if (got.handle !== want.handle)
         report($sformatf("handle %0d, predicted %0d", got.handle, want.handle));
      if (got.base !== want.base)
         report($sformatf("base %h, predicted %h", got.base, want.base));
      if (got.length !== want.length)
         report($sformatf("length %h, predicted %h", got.length, want.length));
      if (got.target !== want.target)
         report($sformatf("target %h, predicted %h", got.target, want.target));
   endtask
endclass

module testbench;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [63:0] req_base_address = '0;
   logic [63:0] req_region_length = '0;
   logic [7:0]  req_handle = '0;
   logic [63:0] req_byte_offset = '0;
   logic [1:0]  req_access_width = '0;
   logic        rsp_strobe;
   logic        rsp_ok;
   logic [6:0]  rsp_result_handle;
   logic [62:0] rsp_entry_base_out;
   logic [62:0] rsp_entry_length_out;
   logic [62:0] rsp_target_address;

   region_table_tracker tracker;
   int                  burst_left;

   io_region_handle_table_core #(
      .TABLE_ENTRIES(TABLE_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_base_address(req_base_address),
      .req_region_length(req_region_length),
      .req_handle(req_handle),
      .req_byte_offset(req_byte_offset),
      .req_access_width(req_access_width),
      .rsp_strobe(rsp_strobe),
      .rsp_ok(rsp_ok),
      .rsp_result_handle(rsp_result_handle),
      .rsp_entry_base_out(rsp_entry_base_out),
      .rsp_entry_length_out(rsp_entry_length_out),
      .rsp_target_address(rsp_target_address)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for the block");
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.compare_result('{ok: rsp_ok, handle: rsp_result_handle,
                                  base: rsp_entry_base_out, length: rsp_entry_length_out,
                                  target: rsp_target_address});
   end

   // issue one transaction, wait until busy drops again, then keep the burst going or idle
   task automatic send_op(input logic [1:0] op, input logic [63:0] b, input logic [63:0] l,
                          input logic [7:0] h, input logic [63:0] off, input logic [1:0] w);
      int gap;
      start <= 1'b1;
      req_opcode <= op;
      req_base_address <= b;
      req_region_length <= l;
      req_handle <= h;
      req_byte_offset <= off;
      req_access_width <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      tracker.apply_request(op, b, l, h, off, w);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
   endtask

   task automatic run_directed();
      send_op(OP_INFO, 0, 0, 8'd1, 0, 2'd0);
      send_op(OP_MAP, 64'd0, 64'd16, 0, 0, 2'd0);
      send_op(OP_MAP, '1, '1, 0, 0, 2'd0);
      send_op(OP_MAP, 64'd4096, 64'd0, 0, 0, 2'd0);
      send_op(OP_MAP, 64'd4096, 64'h8000_0000_0000_0000, 0, 0, 2'd0);
      send_op(OP_MAP, ADDR_LIMIT, 64'd1, 0, 0, 2'd0);
      send_op(OP_MAP, 64'd1, ADDR_LIMIT - 1, 0, 0, 2'd0);
      send_op(OP_MAP, 64'd1, ADDR_LIMIT - 1, 0, 0, 2'd0);
      send_op(OP_MAP, 64'd4096, 64'd64, 0, 0, 2'd0);
      send_op(OP_CHECK, 0, 0, 8'd2, 64'd60, 2'd2);
      send_op(OP_CHECK, 0, 0, 8'd2, 64'd62, 2'd2);
      send_op(OP_CHECK, 0, 0, 8'd2, 64'd64, 2'd0);
      send_op(OP_CHECK, 0, 0, 8'd2, -64'sd4, 2'd2);
      send_op(OP_CHECK, 0, 0, 8'd2, 64'd0, WIDTH_NONE);
      send_op(OP_CHECK, 0, 0, 8'd0, 64'd0, 2'd0);
      send_op(OP_CHECK, 0, 0, 8'd1, ADDR_LIMIT - 2, 2'd0);
      send_op(OP_INFO, 0, 0, 8'd17, 0, 2'd0);
      send_op(OP_INFO, 0, 0, 8'd1, 0, 2'd0);
      // fill the remaining entries, the last map finds no free entry
      for (int k = 0; k < TABLE_SIZE - 1; k++)
         send_op(OP_MAP, 64'(k + 2) << 16, 64'd256, 0, 0, 2'd0);
      send_op(OP_CLEAR, '1, '1, 8'hff, '1, 2'd3);
      send_op(OP_INFO, 0, 0, 8'd2, 0, 2'd0);
   endtask

   task automatic run_random(input int count);
      logic [1:0]  op;
      logic [63:0] b;
      logic [63:0] l;
      logic [7:0]  h;
      logic [63:0] off;
      logic [1:0]  w;
      logic [63:0] rl;
      int          pick;
      int          flavor;
      for (int i = 0; i < count; i++) begin
         b = {$urandom, $urandom};
         l = {$urandom, $urandom};
         h = 8'($urandom_range(0, 255));
         off = {$urandom, $urandom};
         w = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         flavor = $urandom_range(0, 9);
         if (pick < 2) begin
            op = OP_CLEAR;
         end else if (pick < 40) begin
            op = OP_MAP;
            if (flavor < 6) begin
               b = 64'($urandom_range(1, 6)) << 12;
               l = 64'($urandom_range(1, 4)) * 8;
            end else if (flavor == 6) begin
               b = ADDR_LIMIT - 64'($urandom_range(0, 300));
               l = 64'($urandom_range(1, 400));
            end else if (flavor == 7) begin
               b = {1'b0, 31'($urandom), 32'($urandom)};
               if (b == 0)
                  b = 64'd1;
               l = ADDR_LIMIT - b + 64'($urandom_range(0, 2)) - 1;
            end else if (flavor == 9) begin
               b = {1'b0, 31'($urandom), 32'($urandom)};
               l = 64'($urandom_range(1, 1 << 20));
            end
         end else if (pick < 78) begin
            op = OP_CHECK;
            if ($urandom_range(0, 9) != 0)
               h = 8'($urandom_range(1, TABLE_SIZE));
            if ($urandom_range(0, 19) != 0)
               w = 2'($urandom_range(0, 2));
            rl = (h >= 1 && h <= TABLE_SIZE) ? {1'b0, tracker.len_q[h - 1]} : 64'd0;
            if (flavor >= 1 && flavor <= 3)
               off = rl - 64'($urandom_range(0, 9));
            else if (flavor >= 4)
               off = (off % (rl + 1)) & ~((64'd1 << w) - 1);
         end else begin
            op = OP_INFO;
            if ($urandom_range(0, 6) != 0)
               h = 8'($urandom_range(1, TABLE_SIZE));
         end
         send_op(op, b, l, h, off, w);
      end
   endtask

   initial begin
      int waited;
      tracker = new();
      burst_left = $urandom_range(1, 10);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(1250);
      start <= 1'b0;
      waited = 0;
      while (tracker.pending_results.size() > 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (tracker.pending_results.size() > 0)
         tracker.report($sformatf("%0d results never arrived",
                                  tracker.pending_results.size()));
      $display("covered %0d clear, %0d map (%0d granted, %0d on a full table),",
               tracker.op_count[OP_CLEAR], tracker.op_count[OP_MAP], tracker.map_granted,
               tracker.full_rejects);
      $display("%0d check, %0d info; %0d results compared, %0d mismatches",
               tracker.op_count[OP_CHECK], tracker.op_count[OP_INFO],
               tracker.result_count, tracker.error_count);
      if (tracker.error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
